// ----- design/lgg_pkg.sv -----
`timescale 1ns / 1ps

package lgg_pkg;

  // Grid geometry
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int COUNT_W = 13;
  localparam int PROD_W  = COORD_W + DIM_W;

  // Sweep step counter covers the line fill plus every store entry
  localparam int STEP_W = $clog2(CELLS + MAX_COLS + 3);

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = DIM_W;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 1'b1;
  localparam int GRID_ROWS_RESET = 64;
  localparam int GRID_COLS_RESET = 64;

  // Function codes; any other code reads
  localparam logic [FUNC_W-1:0] FUNC_TOGGLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
  } lgg_req_t;

  typedef struct packed {
    logic               cell_alive;
    logic [COUNT_W-1:0] live_total;
    logic               status;
  } lgg_res_t;

  // Write side of one cell bank
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              data;
  } lgg_wr_t;

endpackage

// ----- design/lgg_cell.sv -----
`timescale 1ns / 1ps

// One stage of a row delay line: load the entry bit or take the neighbor's bit
module lgg_cell (
  input  logic clk,
  input  logic prev,
  input  logic din,
  input  logic inject,
  output logic q
);

  always_ff @(posedge clk) begin
    q <= inject ? din : prev;
  end

endmodule

// ----- design/lgg_row_line.sv -----
`timescale 1ns / 1ps

// Row delay line: the stream enters the chain cols cells
// before its end and moves one cell per cycle.
module lgg_row_line (
  input  logic                      clk,
  input  logic                      din,
  input  logic [lgg_pkg::DIM_W-1:0] cols,
  output logic                      dout
);
  import lgg_pkg::*;

  logic [MAX_COLS-1:0] tap;
  logic [DIM_W-1:0]    entry;

  // Pick the entry cell from the column count
  assign entry = DIM_W'(MAX_COLS) - cols;

  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    logic prev;
    logic inject;
    if (k == 0) begin : g_head
      assign prev = 1'b0;
    end else begin : g_body
      assign prev = tap[k-1];
    end
    assign inject = (entry == DIM_W'(k));
    lgg_cell u_cell (
      .clk    (clk),
      .prev   (prev),
      .din    (din),
      .inject (inject),
      .q      (tap[k])
    );
  end

  assign dout = tap[MAX_COLS-1];

endmodule

// ----- design/lgg_bank.sv -----
`timescale 1ns / 1ps

// One bit-wide cell bank: one write and one registered read per cycle
module lgg_bank (
  input  logic                       clk,
  input  logic                       we,
  input  lgg_pkg::lgg_wr_t           wr,
  input  logic [lgg_pkg::ADDR_W-1:0] raddr,
  output logic                       rdata
);
  import lgg_pkg::*;

  logic mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/life_grid_generation.sv -----
`timescale 1ns / 1ps

// Bounded Game of Life grid (B3/S23) with a live-cell count. One request is
// taken at a time and gives one result. Toggle and read pass through a read
// state and an update state; an off-grid one goes straight to the finish
// state. In an advance every one of the 4096 store entries goes past the
// single read port of the active bank, streamed in raster order through
// two row delay lines that form the 3x3 neighborhood, while the new
// generation is written into the other bank, which then becomes the grid.
// After reset the block runs a clearing pass over every entry of the active
// bank and holds req_stall high meanwhile; configuration writes are taken at
// any time but are meant for idle periods only.
module life_grid_generation (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  lgg_pkg::lgg_req_t               req_data,
  output logic                            res_valid,
  input  logic                            res_stall,
  output lgg_pkg::lgg_res_t               res_data,
  input  logic                            cfg_write,
  input  logic [lgg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lgg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lgg_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  state_t             state;
  logic [DIM_W-1:0]   grid_rows;
  logic [DIM_W-1:0]   grid_cols;
  logic [DIM_W-1:0]   rows;
  logic [DIM_W-1:0]   cols;
  logic               bank;
  logic [STEP_W-1:0]  step;
  logic [ADDR_W-1:0]  ci;
  logic [DIM_W-1:0]   cr;
  logic [DIM_W-1:0]   cc;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] cnt_next;
  logic [COUNT_W-1:0] live_count;
  logic [COUNT_W-1:0] toggle_count;
  logic [ADDR_W-1:0]  idx;
  logic               is_toggle;
  logic               res_alive;
  logic               res_status;

  logic [PROD_W-1:0]  prod;
  logic               out_of_range;
  logic               out_free;
  logic               res_load;
  logic               ctr_on;
  logic               in_grid;
  logic               cc_wrap;
  logic               top_ok;
  logic               bot_ok;
  logic               left_ok;
  logic               right_ok;
  logic [7:0]         nbr;
  logic [3:0]         nsum;
  logic               next_alive;

  logic               we0;
  logic               we1;
  lgg_wr_t            wr;
  logic [ADDR_W-1:0]  raddr;
  logic               rd0;
  logic               rd1;
  logic               rd;

  // Window taps: bottom row h*, middle row m*, top row t*
  logic               h0, h1, h2;
  logic               m0, m1, m2;
  logic               t0, t1, t2;

  // Clamp a register value to 1..max
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign rows = eff_dim(grid_rows, DIM_W'(MAX_ROWS));
  assign cols = eff_dim(grid_cols, DIM_W'(MAX_COLS));

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = ((state == ST_UPDATE) || (state == ST_FINISH)) && out_free;

  // Decode the incoming request
  assign prod = PROD_W'(req_data.cell_row) * PROD_W'(cols) + PROD_W'(req_data.cell_col);
  assign out_of_range = (DIM_W'(req_data.cell_row) >= rows) ||
                        (DIM_W'(req_data.cell_col) >= cols);

  // Cell banks
  assign rd = bank ? rd1 : rd0;
  assign h0 = rd;
  assign raddr = (state == ST_SWEEP) ? step[ADDR_W-1:0] : idx;

  lgg_bank u_bank0 (.clk(clk), .we(we0), .wr(wr), .raddr(raddr), .rdata(rd0));
  lgg_bank u_bank1 (.clk(clk), .we(we1), .wr(wr), .raddr(raddr), .rdata(rd1));

  // Row delay lines
  lgg_row_line u_line_mid (.clk(clk), .din(h0), .cols(cols), .dout(m0));
  lgg_row_line u_line_top (.clk(clk), .din(m0), .cols(cols), .dout(t0));

  // Shift the window columns
  always_ff @(posedge clk) begin
    h1 <= h0;
    h2 <= h1;
    m1 <= m0;
    m2 <= m1;
    t1 <= t0;
    t2 <= t1;
  end

  // Neighborhood of the center cell m1, edges count as dead
  assign ctr_on   = (state == ST_SWEEP) && (step >= STEP_W'(cols) + STEP_W'(2));
  assign in_grid  = (cr < rows);
  assign top_ok   = (cr != '0);
  assign bot_ok   = ((cr + DIM_W'(1)) < rows);
  assign left_ok  = (cc != '0);
  assign right_ok = ((cc + DIM_W'(1)) < cols);
  assign cc_wrap  = ((cc + DIM_W'(1)) == cols);

  assign nbr = {top_ok & left_ok & t2, top_ok & t1, top_ok & right_ok & t0,
                left_ok & m2, right_ok & m0,
                bot_ok & left_ok & h2, bot_ok & h1, bot_ok & right_ok & h0};
  assign nsum = 4'($countones(nbr));
  assign next_alive = in_grid && ((nsum == 4'd3) || (m1 && (nsum == 4'd2)));
  assign cnt_next = cnt + COUNT_W'(next_alive);

  assign toggle_count = rd ? (live_count - COUNT_W'(1)) : (live_count + COUNT_W'(1));

  // Steer bank writes: clearing pass, new generation, or toggle
  always_comb begin
    we0     = 1'b0;
    we1     = 1'b0;
    wr.addr = ci;
    wr.data = 1'b0;
    case (state)
      ST_CLEAR: begin
        we0 = 1'b1;
      end
      ST_SWEEP: begin
        wr.data = next_alive;
        if (ctr_on) begin
          we0 = bank;
          we1 = !bank;
        end
      end
      ST_UPDATE: begin
        wr.addr = idx;
        wr.data = !rd;
        if (is_toggle && out_free) begin
          we0 = !bank;
          we1 = bank;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      ci         <= '0;
      bank       <= 1'b0;
      live_count <= '0;
      res_valid  <= 1'b0;
      grid_rows  <= DIM_W'(GRID_ROWS_RESET);
      grid_cols  <= DIM_W'(GRID_COLS_RESET);
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_ROWS: grid_rows <= cfg_data;
          REG_GRID_COLS: grid_cols <= cfg_data;
          default: begin
          end
        endcase
      end

      // Raise the result when loaded, drop it once taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          ci <= ci + ADDR_W'(1);
          if (ci == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            idx       <= prod[ADDR_W-1:0];
            is_toggle <= (req_data.func == FUNC_TOGGLE);
            if (req_data.func == FUNC_ADVANCE) begin
              step  <= '0;
              ci    <= '0;
              cr    <= '0;
              cc    <= '0;
              cnt   <= '0;
              state <= ST_SWEEP;
            end else if (out_of_range) begin
              res_alive  <= 1'b0;
              res_status <= 1'b1;
              state      <= ST_FINISH;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            res_data.status <= 1'b0;
            if (is_toggle) begin
              res_data.cell_alive <= !rd;
              res_data.live_total <= toggle_count;
              live_count          <= toggle_count;
            end else begin
              res_data.cell_alive <= rd;
              res_data.live_total <= live_count;
            end
            state <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          step <= step + STEP_W'(1);
          if (ctr_on) begin
            ci  <= ci + ADDR_W'(1);
            cnt <= cnt_next;
            if (cc_wrap) begin
              cc <= '0;
              if (in_grid) begin
                cr <= cr + DIM_W'(1);
              end
            end else begin
              cc <= cc + DIM_W'(1);
            end
            // Last entry written: swap banks and publish the count
            if (ci == LAST_ADDR) begin
              live_count <= cnt_next;
              bank       <= !bank;
              res_alive  <= 1'b0;
              res_status <= 1'b0;
              state      <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            res_data.cell_alive <= res_alive;
            res_data.live_total <= live_count;
            res_data.status     <= res_status;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/lgg_checker.sv -----
`timescale 1ns / 1ps

module lgg_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              res_valid,
  input logic              res_stall,
  input lgg_pkg::lgg_res_t res_data
);
  import lgg_pkg::*;

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed or dropped");

  // Go busy after taking a request
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous one in flight");

  // A result shows up only out of a request in flight
  a_res_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result without a request in flight");

  // Live count never exceeds the store size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.live_total <= COUNT_W'(CELLS))
    else $error("live count beyond store size");

  // Ignored coordinates report a dead cell
  a_status_dead: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status |-> !res_data.cell_alive)
    else $error("out of range result reports a live cell");

endmodule

bind life_grid_generation lgg_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

// ----- tb/life_grid_checker.sv -----
`timescale 1ns / 1ps

module life_grid_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  lgg_pkg::lgg_req_t               req_data,
  input  logic                            res_valid,
  input  logic                            res_stall,
  input  lgg_pkg::lgg_res_t               res_data,
  input  logic                            cfg_write,
  input  logic [lgg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lgg_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              outstanding
);

  import lgg_pkg::*;

  // Shadow copy of the grid, the live count and the two size registers
  bit                 cell_map [CELLS];
  logic [COUNT_W-1:0] live_cnt;
  logic [DIM_W-1:0]   rows_reg;
  logic [DIM_W-1:0]   cols_reg;
  lgg_res_t           pending_res_q [$];
  int                 mismatches;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  // Clamp a size register to the range the grid supports
  function automatic int span(logic [DIM_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Apply one request to the shadow grid and form the result it gives
  task automatic apply_request(input lgg_req_t rq, output lgg_res_t rs);
    int rows;
    int cols;
    int idx;
    int n;
    int nr;
    int nc;
    int cnt;
    bit alive;
    bit nxt [CELLS];
    rows = span(rows_reg, MAX_ROWS);
    cols = span(cols_reg, MAX_COLS);
    rs = '0;
    if (rq.func == FUNC_ADVANCE) begin
      // Build the next generation; everything beyond the grid ends up dead
      for (int i = 0; i < CELLS; i++) nxt[i] = 1'b0;
      cnt = 0;
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              nr = r + dr;
              nc = c + dc;
              if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols)
                n += cell_map[nr * cols + nc];
            end
          end
          idx   = r * cols + c;
          alive = cell_map[idx];
          nxt[idx] = alive ? (n == 2 || n == 3) : (n == 3);
          if (nxt[idx]) cnt++;
        end
      end
      cell_map = nxt;
      live_cnt = COUNT_W'(cnt);
    end else if (rq.cell_row >= rows || rq.cell_col >= cols) begin
      // Off-grid toggle or read: leave the grid alone
      rs.status = 1'b1;
    end else begin
      idx = rq.cell_row * cols + rq.cell_col;
      if (rq.func == FUNC_TOGGLE) begin
        cell_map[idx] = !cell_map[idx];
        if (cell_map[idx]) live_cnt = live_cnt + 1'b1;
        else live_cnt = live_cnt - 1'b1;
      end
      rs.cell_alive = cell_map[idx];
    end
    rs.live_total = live_cnt;
  endtask

  // Count a mismatch; show only the first few
  task automatic report(input string what, input lgg_res_t want, input lgg_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected alive=%0b total=%0d status=%0b, got alive=%0b total=%0d status=%0b",
               $realtime, what, want.cell_alive, want.live_total, want.status,
               got.cell_alive, got.live_total, got.status);
  endtask

  // Track configuration, predict on each request, compare each result
  always @(posedge clk) begin
    lgg_res_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) cell_map[i] = 1'b0;
      live_cnt = '0;
      rows_reg = DIM_W'(GRID_ROWS_RESET);
      cols_reg = DIM_W'(GRID_COLS_RESET);
      pending_res_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_ROWS: rows_reg = cfg_data;
          REG_GRID_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        apply_request(req_data, want);
        pending_res_q.push_back(want);
      end
      if (res_valid && !res_stall) begin
        if (pending_res_q.size() == 0) begin
          report("result with no request waiting", '0, res_data);
        end else begin
          want = pending_res_q.pop_front();
          if (res_data.cell_alive !== want.cell_alive ||
              res_data.live_total !== want.live_total ||
              res_data.status !== want.status)
            report("result mismatch", want, res_data);
        end
      end
    end
    outstanding <= pending_res_q.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- tb/tb_life_grid_generation.sv -----
`timescale 1ns / 1ps

module tb_life_grid_generation;

  import lgg_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int ADV_CAP      = 36;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 32;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   req_valid;
  logic                   req_stall;
  lgg_req_t               req_data;
  logic                   res_valid;
  logic                   res_stall;
  lgg_res_t               res_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     outstanding;

  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     hold_requests = 0;
  int                     items_done    = 0;
  int                     adv_count     = 0;
  logic [DIM_W-1:0]       rows_now;
  logic [DIM_W-1:0]       cols_now;

  always #6 clk = ~clk;

  life_grid_generation i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  life_grid_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Stall the result side at random, or hold it off for a long stretch on demand
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else begin
        res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Bound the whole run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int dim_used(logic [DIM_W-1:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  // Offer one request, with a random gap first, and hold it until taken
  task automatic put_req(input logic [FUNC_W-1:0] f, input int r, input int c);
    lgg_req_t rq;
    rq.func     = f;
    rq.cell_row = COORD_W'(r);
    rq.cell_col = COORD_W'(c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_done++;
    if (f == FUNC_ADVANCE) adv_count++;
  endtask

  // Drop valid and wait until every result has come back or the wait limit runs out
  task automatic wait_drained();
    int waited;
    waited = 0;
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
  endtask

  // Write both size registers on consecutive edges
  task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_GRID_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_write <= 1'b0;
    rows_now = rows;
    cols_now = cols;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: return DIM_W'(0);
          1: return DIM_W'(1);
          2: return DIM_W'(64);
          default: return DIM_W'(127);
        endcase
      end
      1: return DIM_W'($urandom_range(1, 10));
      2: return DIM_W'($urandom_range(0, 127));
      default: return DIM_W'($urandom_range(1, 64));
    endcase
  endfunction

  // Seed a small cluster, step it while advances remain, then read around it
  task automatic pattern_episode();
    int er;
    int ec;
    int r0;
    int c0;
    er = dim_used(rows_now, MAX_ROWS);
    ec = dim_used(cols_now, MAX_COLS);
    r0 = $urandom_range(0, er - 1);
    c0 = $urandom_range(0, ec - 1);
    repeat ($urandom_range(3, 7))
      put_req(FUNC_TOGGLE, (r0 + $urandom_range(0, 2)) % er, (c0 + $urandom_range(0, 2)) % ec);
    if (adv_count < ADV_CAP)
      repeat ($urandom_range(1, 2)) put_req(FUNC_ADVANCE, $urandom_range(0, 63),
                                            $urandom_range(0, 63));
    repeat ($urandom_range(2, 4))
      put_req(FUNC_READ, (r0 + $urandom_range(0, 3)) % er, (c0 + $urandom_range(0, 3)) % ec);
  endtask

  // Any code, any coordinate; keep advances rare
  task automatic noise_episode();
    logic [FUNC_W-1:0] f;
    repeat ($urandom_range(4, 8)) begin
      f = FUNC_W'($urandom_range(0, 3));
      if (f == FUNC_ADVANCE && (adv_count >= ADV_CAP || $urandom_range(0, 2) != 0))
        f = FUNC_SPARE;
      put_req(f, $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  initial begin
    int phase_start;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_data  = '0;
    cfg_write = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_data  = '0;
    rows_now  = DIM_W'(GRID_ROWS_RESET);
    cols_now  = DIM_W'(GRID_COLS_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Full grid at reset size: corners, double toggle, spare code, a blinker
    send_idle_pct = 33;
    recv_idle_pct <= 54;
    put_req(FUNC_READ, 0, 0);
    put_req(FUNC_TOGGLE, 0, 0);
    put_req(FUNC_TOGGLE, 63, 63);
    put_req(FUNC_TOGGLE, 0, 63);
    put_req(FUNC_TOGGLE, 63, 0);
    put_req(FUNC_TOGGLE, 0, 0);
    put_req(FUNC_SPARE, 63, 63);
    put_req(FUNC_TOGGLE, 10, 9);
    put_req(FUNC_TOGGLE, 10, 10);
    put_req(FUNC_TOGGLE, 10, 11);
    put_req(FUNC_ADVANCE, 63, 63);
    put_req(FUNC_READ, 9, 10);
    put_req(FUNC_READ, 10, 9);

    // Zero rows and oversized columns: a single row of 64
    wait_drained();
    set_grid(DIM_W'(0), DIM_W'(127));
    put_req(FUNC_TOGGLE, 0, 5);
    put_req(FUNC_TOGGLE, 0, 6);
    put_req(FUNC_TOGGLE, 0, 7);
    put_req(FUNC_TOGGLE, 1, 5);
    put_req(FUNC_ADVANCE, 0, 0);
    put_req(FUNC_READ, 0, 6);

    // Oversized rows, one column: old bits reread at new positions
    wait_drained();
    set_grid(DIM_W'(127), DIM_W'(1));
    put_req(FUNC_TOGGLE, 63, 0);
    put_req(FUNC_READ, 5, 1);
    put_req(FUNC_ADVANCE, 0, 0);

    // One cell grid
    wait_drained();
    set_grid(DIM_W'(1), DIM_W'(0));
    put_req(FUNC_TOGGLE, 0, 0);
    put_req(FUNC_TOGGLE, 0, 1);
    put_req(FUNC_ADVANCE, 0, 0);

    // Random phases: sender-light, receiver-light, then no idling with a long hold
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      set_grid(pick_dim(), pick_dim());
      case (ph)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct <= 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct <= 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_start = items_done;
      if (ph == 2) begin
        // Hold results back while requests keep coming
        hold_requests <= hold_requests + 1;
        repeat (8)
          put_req($urandom_range(0, 1) ? FUNC_TOGGLE : FUNC_READ,
                  $urandom_range(0, 63), $urandom_range(0, 63));
      end
      while (items_done - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          wait_drained();
          set_grid(pick_dim(), pick_dim());
        end
        if ($urandom_range(0, 9) < 6) pattern_episode();
        else noise_episode();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
